/* sv/tgc_pkg.sv */
// Shared types and constants for the touch gesture classifier.
// No dependencies; imported by every module of the block.
package tgc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned DurW    = 32;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [SampleW-1:0] PressThrRst   = 12'd2500;
  localparam logic [SampleW-1:0] ReleaseThrRst = 12'd2000;
  localparam logic [LimitW-1:0]  TapLimitRst   = 16'd500;
  localparam logic [LimitW-1:0]  HoldLimitRst  = 16'd1000;
  localparam logic [LimitW-1:0]  DtWindowRst   = 16'd500;

  typedef enum logic [2:0] {
    REG_PRESS_THR   = 3'd0,
    REG_RELEASE_THR = 3'd1,
    REG_TAP_LIMIT   = 3'd2,
    REG_HOLD_LIMIT  = 3'd3,
    REG_DT_WINDOW   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PRESS      = 3'd1,
    EV_SINGLE_TAP = 3'd2,
    EV_DOUBLE_TAP = 3'd3,
    EV_HOLD       = 3'd4,
    EV_MEDIUM     = 3'd5
  } event_e;

  typedef struct packed {
    logic [SampleW-1:0] press_thr;
    logic [SampleW-1:0] release_thr;
    logic [LimitW-1:0]  tap_limit;
    logic [LimitW-1:0]  hold_limit;
    logic [LimitW-1:0]  dt_window;
  } cfg_t;

  typedef struct packed {
    logic            pressed;
    event_e          event_res;
    logic [DurW-1:0] duration;
  } res_t;

endpackage

/* sv/tgc_cfg_regs.sv */
// APB-style configuration registers of the touch gesture classifier.
// Depends on tgc_pkg.
module tgc_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tgc_pkg::AddrW-1:0] paddr,
  input  logic [tgc_pkg::DataW-1:0] pwdata,
  output logic [tgc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output tgc_pkg::cfg_t             cfg_o
);
  import tgc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PRESS_THR:   cfg_d.press_thr   = pwdata[SampleW-1:0];
        REG_RELEASE_THR: cfg_d.release_thr = pwdata[SampleW-1:0];
        REG_TAP_LIMIT:   cfg_d.tap_limit   = pwdata[LimitW-1:0];
        REG_HOLD_LIMIT:  cfg_d.hold_limit  = pwdata[LimitW-1:0];
        REG_DT_WINDOW:   cfg_d.dt_window   = pwdata[LimitW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRESS_THR:   prdata = DataW'(cfg_q.press_thr);
      REG_RELEASE_THR: prdata = DataW'(cfg_q.release_thr);
      REG_TAP_LIMIT:   prdata = DataW'(cfg_q.tap_limit);
      REG_HOLD_LIMIT:  prdata = DataW'(cfg_q.hold_limit);
      REG_DT_WINDOW:   prdata = DataW'(cfg_q.dt_window);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_thr   <= PressThrRst;
      cfg_q.release_thr <= ReleaseThrRst;
      cfg_q.tap_limit   <= TapLimitRst;
      cfg_q.hold_limit  <= HoldLimitRst;
      cfg_q.dt_window   <= DtWindowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/tgc_step.sv */
// Gesture state and per-sample classification logic.
// Depends on tgc_pkg. State advances only on a step strobe from the top level.
module tgc_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [tgc_pkg::SampleW-1:0] sample_i,
  input  tgc_pkg::cfg_t               cfg_i,
  output tgc_pkg::res_t               res_o
);
  import tgc_pkg::*;

  logic                 pressed_q, pressed_d;
  logic                 was_tap_q, was_tap_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] tap_time_q, tap_time_d;

  logic [TIME_BITS-1:0] dur, gap;
  logic [DurW-1:0]      dur_sat;
  logic                 do_press, do_release;

  assign time_d     = time_q + TIME_BITS'(1);
  assign dur        = time_d - start_q;
  assign gap        = time_d - tap_time_q;
  assign do_press   = (sample_i > cfg_i.press_thr) && !pressed_q;
  assign do_release = (sample_i < cfg_i.release_thr) && pressed_q;

  // duration field saturates when the time counter is wider than the field
  if (TIME_BITS > DurW) begin : g_sat
    assign dur_sat = (|dur[TIME_BITS-1:DurW]) ? '1 : dur[DurW-1:0];
  end else begin : g_ext
    assign dur_sat = DurW'(dur);
  end

  always_comb begin
    pressed_d       = pressed_q;
    was_tap_d       = was_tap_q;
    start_d         = start_q;
    tap_time_d      = tap_time_q;
    res_o.event_res = EV_NONE;
    res_o.duration  = '0;
    priority if (do_press) begin
      pressed_d       = 1'b1;
      start_d         = time_d;
      res_o.event_res = EV_PRESS;
    end else if (do_release) begin
      pressed_d      = 1'b0;
      res_o.duration = dur_sat;
      priority if (dur < TIME_BITS'(cfg_i.tap_limit)) begin
        if (was_tap_q && (gap < TIME_BITS'(cfg_i.dt_window))) begin
          res_o.event_res = EV_DOUBLE_TAP;
          was_tap_d       = 1'b0;
        end else begin
          res_o.event_res = EV_SINGLE_TAP;
          was_tap_d       = 1'b1;
          tap_time_d      = time_d;
        end
      end else if (dur > TIME_BITS'(cfg_i.hold_limit)) begin
        res_o.event_res = EV_HOLD;
        was_tap_d       = 1'b0;
      end else begin
        res_o.event_res = EV_MEDIUM;
        was_tap_d       = 1'b0;
      end
    end else begin
      // hysteresis zone: hold state
    end
    res_o.pressed = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q  <= 1'b0;
      was_tap_q  <= 1'b0;
      time_q     <= '0;
      start_q    <= '0;
      tap_time_q <= '0;
    end else if (step_i) begin
      pressed_q  <= pressed_d;
      was_tap_q  <= was_tap_d;
      time_q     <= time_d;
      start_q    <= start_d;
      tap_time_q <= tap_time_d;
    end
  end

endmodule

/* sv/touch_gesture_classifier_core.sv */
// Top level of the touch gesture classifier: input register, step logic, result register.
// Depends on tgc_pkg, tgc_cfg_regs and tgc_step.
//
// Usage:
//   One 12-bit sample enters per beat on the sample channel (sample_valid_i /
//   sample_ready_o). Each sample gives exactly one result beat on the result
//   channel (result_valid_o / result_ready_i): pressed state, event code
//   (none, press, single tap, double tap, hold, medium release) and the touch
//   duration in samples on release events.
//   A sample passes the input register, then the step logic, then the result
//   register, whose load raises result_valid_o. Throughput: one sample per cycle
//   while result_ready_i is high; the compare/subtract path between the two
//   registers is combinational. Stall: when the receiver holds result_ready_i
//   low, the result register holds its beat, the input register takes one more
//   sample if it is empty, and then sample_ready_o drops until the result is
//   taken. Reset: rst_ni clears the gesture state, the sample-time counter and
//   both valid flags, and loads the threshold and limit registers with defaults.
//   Thresholds and limits are written through the APB-style port; the user must
//   write them only while idle, as the block itself does not enforce it.
module touch_gesture_classifier_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgc_pkg::AddrW-1:0]   paddr,
  input  logic [tgc_pkg::DataW-1:0]   pwdata,
  output logic [tgc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        sample_valid_i,
  output logic                        sample_ready_o,
  input  logic [tgc_pkg::SampleW-1:0] sample_i,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic                        pressed_o,
  output tgc_pkg::event_e             event_res_o,
  output logic [tgc_pkg::DurW-1:0]    duration_o
);
  import tgc_pkg::*;

  cfg_t               cfg;
  res_t               res, res_q;
  logic               in_valid_q, out_valid_q;
  logic [SampleW-1:0] sample_q;
  logic               step;

  tgc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage 1 moves forward whenever it holds a sample and the result register is free or draining
  assign step           = in_valid_q && (!out_valid_q || result_ready_i);
  assign sample_ready_o = !in_valid_q || step;

  tgc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_ready_o) in_valid_q <= sample_valid_i;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_valid_i && sample_ready_o) sample_q <= sample_i;
    if (step) res_q <= res;
  end

  assign result_valid_o = out_valid_q;
  assign pressed_o      = res_q.pressed;
  assign event_res_o    = res_q.event_res;
  assign duration_o     = res_q.duration;

endmodule

/* bench/touch_gesture_classifier_checker.sv */
// Scoreboard for the touch gesture classifier: follows register traffic on the APB port,
// predicts one result beat per accepted sample and compares it with the block's output.
// Depends on tgc_pkg.
module touch_gesture_classifier_checker
  import tgc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  input  logic [DataW-1:0]   prdata,
  input  logic               pready,
  input  logic               sample_valid_i,
  input  logic               sample_ready_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic               result_valid_o,
  input  logic               result_ready_i,
  input  logic               pressed_o,
  input  event_e             event_res_o,
  input  logic [DurW-1:0]    duration_o,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);

  localparam logic [63:0] TimeMask =
    (TIME_BITS >= 64) ? {64{1'b1}} : ((64'd1 << TIME_BITS) - 64'd1);

  cfg_t        cfg;
  logic        touching;
  logic        tap_armed;
  logic [63:0] now_t;
  logic [63:0] touch_start_t;
  logic [63:0] last_tap_t;
  res_t        gesture_q[$];
  int unsigned errors;

  // Advances the sample clock and runs the hysteresis / gesture decision for one sample.
  function automatic res_t classify_sample(input logic [SampleW-1:0] s);
    res_t        r;
    logic [63:0] span;
    logic [63:0] since_tap;
    r = '0;
    now_t = (now_t + 64'd1) & TimeMask;
    if (s > cfg.press_thr && !touching) begin
      touching      = 1'b1;
      touch_start_t = now_t;
      r.event_res   = EV_PRESS;
    end else if (s < cfg.release_thr && touching) begin
      touching = 1'b0;
      span     = (now_t - touch_start_t) & TimeMask;
      // tap test wins over the hold test when the limits overlap
      if (span < 64'(cfg.tap_limit)) begin
        since_tap = (now_t - last_tap_t) & TimeMask;
        if (tap_armed && since_tap < 64'(cfg.dt_window)) begin
          r.event_res = EV_DOUBLE_TAP;
          tap_armed   = 1'b0;
        end else begin
          r.event_res = EV_SINGLE_TAP;
          tap_armed   = 1'b1;
          last_tap_t  = now_t;
        end
      end else begin
        r.event_res = (span > 64'(cfg.hold_limit)) ? EV_HOLD : EV_MEDIUM;
        tap_armed   = 1'b0;
      end
      // reported duration saturates, classification used the full span
      r.duration = (span > 64'hFFFF_FFFF) ? {DurW{1'b1}} : span[DurW-1:0];
    end
    r.pressed = touching;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    res_t             want;
    logic             mapped;
    logic [DataW-1:0] held;
    if (!rst_ni) begin
      cfg = '{press_thr: PressThrRst, release_thr: ReleaseThrRst, tap_limit: TapLimitRst,
              hold_limit: HoldLimitRst, dt_window: DtWindowRst};
      touching      = 1'b0;
      tap_armed     = 1'b0;
      now_t         = '0;
      touch_start_t = '0;
      last_tap_t    = '0;
      gesture_q.delete();
      errors        = 0;
      pending_o    <= 0;
      errors_o     <= 0;
    end else begin
      if (psel && penable && pready) begin
        mapped = 1'b1;
        held   = '0;
        case (reg_idx_e'(paddr[AddrW-1:2]))
          REG_PRESS_THR: begin
            if (pwrite) cfg.press_thr = pwdata[SampleW-1:0];
            held = DataW'(cfg.press_thr);
          end
          REG_RELEASE_THR: begin
            if (pwrite) cfg.release_thr = pwdata[SampleW-1:0];
            held = DataW'(cfg.release_thr);
          end
          REG_TAP_LIMIT: begin
            if (pwrite) cfg.tap_limit = pwdata[LimitW-1:0];
            held = DataW'(cfg.tap_limit);
          end
          REG_HOLD_LIMIT: begin
            if (pwrite) cfg.hold_limit = pwdata[LimitW-1:0];
            held = DataW'(cfg.hold_limit);
          end
          REG_DT_WINDOW: begin
            if (pwrite) cfg.dt_window = pwdata[LimitW-1:0];
            held = DataW'(cfg.dt_window);
          end
          default: mapped = 1'b0;
        endcase
        if (!pwrite && mapped && prdata !== held) begin
          $display("%0t: register read at 0x%0h: expected 0x%0h, got 0x%0h",
                   $time, paddr, held, prdata);
          errors++;
        end
      end

      if (sample_valid_i && sample_ready_o) gesture_q.push_back(classify_sample(sample_i));

      if (result_valid_o && result_ready_i) begin
        if (gesture_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got pressed %0b event %0d dur %0d",
                   $time, pressed_o, event_res_o, duration_o);
          errors++;
        end else begin
          want = gesture_q.pop_front();
          if (pressed_o !== want.pressed) begin
            $display("%0t: pressed: expected %0b, got %0b", $time, want.pressed, pressed_o);
            errors++;
          end
          if (event_res_o !== want.event_res) begin
            $display("%0t: event: expected %0d, got %0d", $time, want.event_res, event_res_o);
            errors++;
          end
          if (duration_o !== want.duration) begin
            $display("%0t: duration: expected %0d, got %0d", $time, want.duration, duration_o);
            errors++;
          end
        end
      end

      // published through nonblocking assignments so the stimulus side never races the update
      pending_o <= gesture_q.size();
      errors_o  <= errors;
    end
  end

endmodule

/* bench/touch_gesture_classifier_core_tb.sv */
// Testbench top for the touch gesture classifier: clock, reset, APB register setup and
// touch-shaped sample stimulus with random idling; the checker does all comparison.
// Depends on tgc_pkg, touch_gesture_classifier_core and touch_gesture_classifier_checker.
module touch_gesture_classifier_core_tb;
  import tgc_pkg::*;

  localparam int unsigned TimeBits = 32;

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [AddrW-1:0]   paddr          = '0;
  logic [DataW-1:0]   pwdata         = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               sample_valid_i = 1'b0;
  logic               sample_ready_o;
  logic [SampleW-1:0] sample_i       = '0;
  logic               result_valid_o;
  logic               result_ready_i = 1'b0;
  logic               pressed_o;
  event_e             event_res_o;
  logic [DurW-1:0]    duration_o;

  int unsigned        pending;
  int unsigned        errors;

  logic               idle_on      = 1'b0;
  int unsigned        stall_left   = 0;
  logic [SampleW-1:0] press_c      = PressThrRst;
  logic [SampleW-1:0] release_c    = ReleaseThrRst;
  logic               stim_pressed = 1'b0;
  int unsigned        samples_sent = 0;
  int unsigned        settings_used = 0;
  int unsigned        p;

  touch_gesture_classifier_core #(.TIME_BITS(TimeBits)) u_top (.*);

  touch_gesture_classifier_checker #(.TIME_BITS(TimeBits)) u_checker (
    .*,
    .pending_o (pending),
    .errors_o  (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 300000);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left != 0) begin
      result_ready_i <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      result_ready_i <= 1'b0;
      stall_left     <= $urandom_range(0, 14);
    end else begin
      result_ready_i <= 1'b1;
    end
  end

  // valid is only dropped here for an idle burst, so back-to-back beats keep it high
  task automatic send_sample(input logic [SampleW-1:0] s);
    int unsigned idle_n;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      idle_n = $urandom_range(1, 15);
      sample_valid_i <= 1'b0;
      repeat (idle_n) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    @(posedge clk_i);
    while (!sample_ready_o) @(posedge clk_i);
    samples_sent++;
    if (s > press_c && !stim_pressed) stim_pressed = 1'b1;
    else if (s < release_c && stim_pressed) stim_pressed = 1'b0;
  endtask

  function automatic logic [SampleW-1:0] below_release();
    return (release_c == '0) ? '0 : SampleW'($urandom_range(0, int'(release_c) - 1));
  endfunction

  // one touch: release if still pressed, press, dur-1 beats held, release, then gap-1 beats released
  task automatic touch(input int unsigned dur, input int unsigned gap);
    if (stim_pressed) send_sample(below_release());
    send_sample((press_c == '1) ? press_c : SampleW'($urandom_range(int'(press_c) + 1, 4095)));
    repeat (dur - 1) send_sample(SampleW'($urandom_range(int'(release_c), 4095)));
    send_sample(below_release());
    repeat (gap - 1) send_sample(SampleW'($urandom_range(0, int'(press_c))));
  endtask

  task automatic run_touches(input int unsigned n, input int unsigned max_dur,
                             input int unsigned max_gap);
    int unsigned goal;
    goal = samples_sent + n;
    while (samples_sent < goal) begin
      if ($urandom_range(0, 6) == 0) send_sample(SampleW'($urandom()));
      else touch($urandom_range(1, max_dur), $urandom_range(1, max_gap));
    end
  endtask

  task automatic wait_drained();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [AddrW-1:0] addr,
                          input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value,
                           input int unsigned w);
    // junk above the register width has to be dropped
    apb_xfer(1'b1, {idx, 2'b00}, value | ($urandom() << w));
    apb_xfer(1'b0, {idx, 2'b00}, '0);
  endtask

  task automatic set_config(input logic [SampleW-1:0] pt, input logic [SampleW-1:0] rt,
                            input logic [LimitW-1:0] tl, input logic [LimitW-1:0] hl,
                            input logic [LimitW-1:0] dw);
    wait_drained();
    write_reg(REG_PRESS_THR, DataW'(pt), SampleW);
    write_reg(REG_RELEASE_THR, DataW'(rt), SampleW);
    write_reg(REG_TAP_LIMIT, DataW'(tl), LimitW);
    write_reg(REG_HOLD_LIMIT, DataW'(hl), LimitW);
    write_reg(REG_DT_WINDOW, DataW'(dw), LimitW);
    // index past the register map: must not land anywhere
    apb_xfer(1'b1, {3'(REG_DT_WINDOW) + 3'($urandom_range(1, 3)), 2'b00}, $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    press_c   = pt;
    release_c = rt;
    settings_used++;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: threshold boundaries, re-press while held, tap then double tap
    send_sample('0);
    send_sample(PressThrRst);
    send_sample('1);
    send_sample(ReleaseThrRst);
    send_sample('1);
    send_sample(ReleaseThrRst - 12'd1);
    send_sample(PressThrRst + 12'd1);
    send_sample('0);
    send_sample(12'd2600);
    send_sample(12'd100);

    // small limits: durations on both limit edges, double-tap window edge
    set_config(PressThrRst, ReleaseThrRst, 16'd3, 16'd5, 16'd4);
    touch(3, 1);
    touch(5, 1);
    touch(6, 1);
    touch(1, 2);
    touch(2, 1);
    touch(1, 1);
    touch(1, 3);

    idle_on <= 1'b1;
    run_touches(70, 10, 8);
    idle_on <= 1'b0;
    run_touches(70, 10, 8);

    repeat (4) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      p = $urandom_range(1500, 4000);
      set_config(SampleW'(p), SampleW'($urandom_range(200, p)), LimitW'($urandom_range(1, 8)),
                 LimitW'($urandom_range(0, 12)), LimitW'($urandom_range(0, 20)));
      run_touches(30, 12, 10);
    end

    idle_on <= 1'b1;
    set_config('1, '0, '0, '1, '0);                     // no press possible
    run_touches(15, 4, 4);
    set_config('0, '1, '1, '0, '1);                     // every touch a tap
    run_touches(25, 4, 4);
    set_config(12'd3000, '0, '0, '0, '0);               // no release possible
    run_touches(15, 4, 4);
    set_config(12'd1000, 12'd3000, '0, '1, 16'd100);    // inverted thresholds, all medium
    run_touches(20, 12, 6);
    set_config(PressThrRst, ReleaseThrRst, '0, '0, '1); // all holds
    run_touches(20, 12, 6);

    idle_on <= 1'b0;
    set_config(PressThrRst, ReleaseThrRst, 16'd4, 16'd8, 16'd12);
    run_touches(60, 10, 8);

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d samples over %0d register settings: hysteresis edges, limit and window",
             samples_sent, settings_used);
    $display("boundaries, register extremes, inverted thresholds and random touch sequences.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tgc_pkg.sv
sv/tgc_cfg_regs.sv
sv/tgc_step.sv
sv/touch_gesture_classifier_core.sv
bench/touch_gesture_classifier_checker.sv
bench/touch_gesture_classifier_core_tb.sv
